// File: rtl/dbcs_pkg.sv
// Package: code page codes, line-break class bundle and lead-byte test.
package dbcs_pkg;

	typedef enum logic [2:0] {
		CP_NONE = 3'd0,
		CP_932  = 3'd1,
		CP_936  = 3'd2,
		CP_949  = 3'd3,
		CP_950  = 3'd4
	} cp_t;

	typedef struct packed {
		logic up;
		logic dn;
		logic brk;
	} class_t;

	function automatic cp_t cp_decode(input logic [2:0] sel);
		cp_t cp;
		cp = (sel > 3'(CP_950)) ? CP_NONE : cp_t'(sel);
		return cp;
	endfunction

	function automatic logic is_lead(input cp_t cp, input logic [7:0] b);
		logic r;
		r = 1'b0;
		unique case (cp)
			CP_932:                 r = (b inside {[8'h81:8'h9f], [8'he0:8'hfc]});
			CP_936, CP_949, CP_950: r = (b inside {[8'h81:8'hfe]});
			default:                r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/dbcs_if.sv
// Interfaces: byte input channel and classified character output channel.
interface dbcs_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;

	modport source (output valid, output text_byte, output end_of_text, input ready);
	modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface dbcs_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] first_byte;
	logic [7:0] second_byte;
	logic       is_double;
	logic       keep_with_previous;
	logic       keep_with_next;
	logic       breakable;
	logic       last_char;

	modport source (output valid, output first_byte, output second_byte, output is_double,
		output keep_with_previous, output keep_with_next, output breakable,
		output last_char, input ready);
	modport sink   (input valid, input first_byte, input second_byte, input is_double,
		input keep_with_previous, input keep_with_next, input breakable,
		input last_char, output ready);
endinterface

// File: rtl/dbcs_classify.sv
// Line-break class rules of each code page for one assembled character.
module dbcs_classify (
	input  dbcs_pkg::cp_t    cp,
	input  logic             dbl,
	input  logic [7:0]       a,
	input  logic [7:0]       b,
	output dbcs_pkg::class_t cls
);

	function automatic logic up_single(input dbcs_pkg::cp_t c, input logic [7:0] x);
		logic r;
		r = 1'b0;
		unique case (c)
			dbcs_pkg::CP_932: r = (x inside {8'h29, 8'h2c, 8'h2e, 8'h3e, 8'h5d, 8'h7d, 8'ha3});
			dbcs_pkg::CP_936: r = (x inside {8'h21, 8'h29, 8'h2c, 8'h2e, 8'h3a, 8'h3b,
				8'h3f, 8'h5d, 8'h7d});
			dbcs_pkg::CP_949: r = (x inside {8'h21, 8'h25, 8'h29, 8'h2c, 8'h2e, 8'h3a,
				8'h3b, 8'h3f, 8'h5d, 8'h7d});
			dbcs_pkg::CP_950: r = (x inside {8'h29, 8'h2c, 8'h2e, 8'h3e, 8'h5d, 8'h7d});
			default:          r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic dn_single(input dbcs_pkg::cp_t c, input logic [7:0] x);
		logic r;
		r = 1'b0;
		unique case (c)
			dbcs_pkg::CP_932: r = (x inside {8'h28, 8'h3c, 8'h5b, 8'h7b, 8'ha2});
			dbcs_pkg::CP_936: r = (x inside {8'h28, 8'h5b, 8'h7b});
			dbcs_pkg::CP_949: r = (x inside {8'h24, 8'h28, 8'h5b, 8'h5c, 8'h7b});
			dbcs_pkg::CP_950: r = (x inside {8'h28, 8'h3c, 8'h5b, 8'h7b});
			default:          r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic up_double(input dbcs_pkg::cp_t c, input logic [7:0] x,
		input logic [7:0] y);
		logic r;
		logic odd;
		odd = y[0];
		r = 1'b0;
		unique case (c)
			dbcs_pkg::CP_932: r = (x == 8'h81) && ((y inside {[8'h41:8'h49]})
				|| ((y inside {[8'h66:8'h72]}) && !odd));
			dbcs_pkg::CP_936: r = ((x == 8'ha1) && (((y inside {[8'ha2:8'had]}) && odd)
				|| (y inside {8'haf, 8'hb1, 8'hb3, 8'hb5, 8'hb7, 8'hb9, 8'hbb, 8'hbd,
				8'hbf, 8'hc3})))
				|| ((x == 8'ha3) && (y inside {8'ha1, 8'ha2, 8'ha7, 8'ha9, 8'hac, 8'hae,
				8'hba, 8'hbb, 8'hbf, 8'hdd, 8'he0, 8'hf3, 8'hfd}));
			dbcs_pkg::CP_949: r = ((x == 8'ha1) && (((y inside {[8'haf:8'hbd]}) && odd)
				|| (y inside {[8'hc6:8'hc9]}) || (y == 8'hcb)))
				|| ((x == 8'ha3) && (y inside {8'ha1, 8'ha5, 8'ha9, 8'hac, 8'hae, 8'hba,
				8'hbb, 8'hbf, 8'hdd, 8'hfd}));
			dbcs_pkg::CP_950: r = (x == 8'ha1) && ((y inside {[8'h41:8'h49]})
				|| (y inside {[8'h4d:8'h54]})
				|| ((y inside {[8'h5e:8'h7e], [8'ha2:8'hac]}) && !odd));
			default:          r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic dn_double(input dbcs_pkg::cp_t c, input logic [7:0] x,
		input logic [7:0] y);
		logic r;
		logic odd;
		odd = y[0];
		r = 1'b0;
		unique case (c)
			dbcs_pkg::CP_932: r = (x == 8'h81) && (y inside {[8'h65:8'h79]}) && odd;
			dbcs_pkg::CP_936: r = ((x == 8'ha1) && (y inside {8'ha4, 8'hae, 8'hb0, 8'hb2,
				8'hb4, 8'hb6, 8'hb8, 8'hba, 8'hbc}))
				|| ((x == 8'ha3) && (y inside {8'ha8, 8'hae, 8'hdb, 8'hfb}));
			dbcs_pkg::CP_949: r = ((x == 8'ha1) && (((y inside {[8'hae:8'hbc]}) && !odd)
				|| (y == 8'hcc)))
				|| ((x == 8'ha3) && (y inside {8'ha4, 8'ha8, 8'hdb, 8'hdc, 8'hf8}));
			dbcs_pkg::CP_950: r = (x == 8'ha1) && (y inside {[8'h5d:8'h7d], [8'ha1:8'hab]})
				&& odd;
			default:          r = 1'b0;
		endcase
		return r;
	endfunction

	logic up_s;
	logic dn_s;
	logic white;

	always_comb begin
		up_s  = up_single(cp, a);
		dn_s  = dn_single(cp, a);
		white = (a inside {8'h20, 8'h09, 8'h0d, 8'h0a});
		cls.up  = dbl ? up_double(cp, a, b) : up_s;
		cls.dn  = dbl ? dn_double(cp, a, b) : dn_s;
		cls.brk = (cp != dbcs_pkg::CP_NONE)
			&& (white || dbcs_pkg::is_lead(cp, a) || up_s || dn_s);
	end

endmodule

// File: rtl/dbcs_kinsoku_char_classifier.sv
// Top level: byte-to-character assembly and line-break classification.
//
// Bytes enter on in_ch (valid/ready); each finished character leaves on
// out_ch with its bytes and its wrap-up, wrap-down and break classes.
// cfg_wr_en/cfg_wr_data set the code page: 0 none, 1 cp932, 2 cp936,
// 3 cp949, 4 cp950; codes 5 to 7 act as none. Write it only while idle.
// A lead byte is held and gives no output; the following byte, whatever its
// value, completes the double-byte character. A lead byte marked as the end
// of the text is sent at once with a trail byte of zero.
// An accepted byte passes the input register, then the result register,
// before its character shows on out_ch.
// Throughput: one byte per cycle while out_ch takes items, set by the single
// classify stage. When out_ch stalls, the result register holds its item,
// the input register takes one more byte, and in_ch.ready drops until the
// result is taken; a held lead byte still moves on, as it produces nothing.
// Reset clears both valid flags, the held lead and the code page (none).
module dbcs_kinsoku_char_classifier (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [2:0] cfg_wr_data,
	dbcs_in_if.sink    in_ch,
	dbcs_out_if.source out_ch
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;
	logic [2:0]       code_page_q;
	logic             lead_pending_q;
	logic [7:0]       held_lead_q;
	logic             out_valid_q;
	logic [7:0]       first_q;
	logic [7:0]       second_q;
	logic             dbl_q;
	dbcs_pkg::class_t cls_q;
	logic             last_q;

	dbcs_pkg::cp_t    cp;
	logic             lead_now;
	logic             hold;
	logic             dbl;
	logic [7:0]       char_a;
	logic [7:0]       char_b;
	logic             out_load;
	logic             adv_s1;
	dbcs_pkg::class_t cls;

	always_comb begin
		cp       = dbcs_pkg::cp_decode(code_page_q);
		lead_now = dbcs_pkg::is_lead(cp, byte_s1);
		hold     = !lead_pending_q && lead_now && !last_s1;
		dbl      = lead_pending_q || (lead_now && last_s1);
		char_a   = lead_pending_q ? held_lead_q : byte_s1;
		char_b   = lead_pending_q ? byte_s1 : 8'h00;
		out_load = !out_valid_q || out_ch.ready;
		adv_s1   = valid_s1 && (hold || out_load);
	end

	dbcs_classify u_classify (
		.cp  (cp),
		.dbl (dbl),
		.a   (char_a),
		.b   (char_b),
		.cls (cls)
	);

	assign in_ch.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_page_q <= 3'(dbcs_pkg::CP_NONE);
		end else if (cfg_wr_en) begin
			code_page_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			byte_s1 <= in_ch.text_byte;
			last_s1 <= in_ch.end_of_text;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_pending_q <= 1'b0;
			held_lead_q    <= 8'h00;
		end else if (adv_s1) begin
			lead_pending_q <= hold;
			held_lead_q    <= hold ? byte_s1 : 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= adv_s1 && !hold;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && adv_s1 && !hold) begin
			first_q  <= char_a;
			second_q <= dbl ? char_b : 8'h00;
			dbl_q    <= dbl;
			cls_q    <= cls;
			last_q   <= last_s1;
		end
	end

	assign out_ch.valid              = out_valid_q;
	assign out_ch.first_byte         = first_q;
	assign out_ch.second_byte        = second_q;
	assign out_ch.is_double          = dbl_q;
	assign out_ch.keep_with_previous = cls_q.up;
	assign out_ch.keep_with_next     = cls_q.dn;
	assign out_ch.breakable          = cls_q.brk;
	assign out_ch.last_char          = last_q;

endmodule

// File: rtl/dbcs_checker.sv
// Checker on the top-level ports, attached by bind.
module dbcs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_first,
	input logic [7:0] out_second,
	input logic       out_double
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_first) && $stable(out_second))
		else $error("output item changed while stalled");

	a_single_trail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_double |-> out_second == 8'h00)
		else $error("single-byte item with nonzero trail byte");

	a_double_lead_high: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_double |-> out_first[7])
		else $error("double-byte item with lead below 0x80");

endmodule

bind dbcs_kinsoku_char_classifier dbcs_checker u_dbcs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.out_first  (out_ch.first_byte),
	.out_second (out_ch.second_byte),
	.out_double (out_ch.is_double)
);
